// File: hdl/odo_pkg.sv
// Shared types and constants for the differential-drive odometry block.
`timescale 1ns / 1ps
package odo_pkg;

  // Configuration register indexes.
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_IWB  = 1'b1;

  // Item operation codes.
  localparam logic OP_INTEGRATE = 1'b0;
  localparam logic OP_RESET     = 1'b1;

  localparam logic [23:0] GAIN_RESET = 24'd19613;
  localparam logic [23:0] IWB_RESET  = 24'd91875;

  // 2^54 / (2*pi*1e6): rad/s times microseconds into binary angle, scaled by 2^38.
  localparam logic [31:0] HEADING_SCALE = 32'd2867080570;

  // CORDIC start value: 2^30 divided by the CORDIC gain.
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;

  // Serial multiplier operand widths and serial divider width.
  localparam int MUL_AW = 52;
  localparam int MUL_BW = 32;
  localparam int DIV_NW = 53;
  localparam logic [19:0] DIVISOR = 20'd1000000;

  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
  } odo_trig_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DIF,
    S_W,
    S_WDT,
    S_HS,
    S_COR_MID,
    S_VC,
    S_VCDT,
    S_DIVX,
    S_VS,
    S_VSDT,
    S_DIVY,
    S_COR_Q,
    S_DONE
  } odo_state_t;

endpackage

// File: hdl/odo_mul.sv
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
`timescale 1ns / 1ps
module odo_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [odo_pkg::MUL_AW-1:0] a,
  input  logic [odo_pkg::MUL_BW-1:0] b,
  output logic done,
  output logic [odo_pkg::MUL_AW+odo_pkg::MUL_BW-1:0] product
);
  import odo_pkg::*;

  localparam int CW = $clog2(MUL_BW + 1);

  logic [MUL_AW-1:0] a_reg;
  logic [MUL_AW+MUL_BW-1:0] p;
  logic [CW-1:0] cnt;
  logic busy;
  logic [MUL_AW:0] acc;

  // The low half holds the remaining multiplier bits; the high half accumulates.
  assign acc = {1'b0, p[MUL_AW+MUL_BW-1:MUL_BW]} + (p[0] ? {1'b0, a_reg} : '0);
  assign product = p;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MUL_BW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      p     <= {{MUL_AW{1'b0}}, b};
    end else if (busy) begin
      p <= {acc, p[MUL_BW-1:1]};
    end
  end

endmodule

// File: hdl/odo_div.sv
// Restoring divider by a fixed constant, one quotient bit per cycle.
`timescale 1ns / 1ps
module odo_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [odo_pkg::DIV_NW-1:0] dividend,
  output logic done,
  output logic [odo_pkg::DIV_NW-1:0] quotient
);
  import odo_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] q;
  logic [19:0] rem;
  logic [20:0] trial;
  logic ge;
  logic [CW-1:0] cnt;
  logic busy;

  assign trial = {rem, q[DIV_NW-1]};
  assign ge = (trial >= {1'b0, DIVISOR});
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? 20'(trial - {1'b0, DIVISOR}) : trial[19:0];
      q   <= {q[DIV_NW-2:0], ge};
    end
  end

endmodule

// File: hdl/odo_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a binary angle.
`timescale 1ns / 1ps
module odo_cordic #(
  parameter int STEPS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [31:0] angle,
  output logic done,
  output odo_pkg::odo_trig_t trig
);
  import odo_pkg::*;

  localparam int N = (STEPS > 32) ? 32 : STEPS;

  logic signed [33:0] x, y, z, dx, dy, at, xc, yc;
  logic [31:0] angf;
  logic [4:0] i;
  logic busy, fin, flip;

  assign dx = x >>> i;
  assign dy = y >>> i;
  assign at = $signed({2'b00, ATAN_TABLE[i]});
  assign angf = (angle[31] ^ angle[30]) ? (angle ^ 32'h8000_0000) : angle;

  always_comb begin
    xc = (x > Q30_ONE) ? Q30_ONE : ((x < -Q30_ONE) ? -Q30_ONE : x);
    yc = (y > Q30_ONE) ? Q30_ONE : ((y < -Q30_ONE) ? -Q30_ONE : y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 1'b1;
        if (i == 5'(N - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // Quadrants two and three are folded onto the right half plane.
      flip <= angle[31] ^ angle[30];
      x    <= CORDIC_START;
      y    <= '0;
      z    <= {{2{angf[31]}}, angf};
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - dy;
        y <= y + dx;
        z <= z - at;
      end else begin
        x <= x + dy;
        y <= y - dx;
        z <= z + at;
      end
    end else if (fin) begin
      trig.cos_v <= flip ? 32'(-xc) : xc[31:0];
      trig.sin_v <= flip ? 32'(-yc) : yc[31:0];
    end
  end

endmodule

// File: hdl/diff_drive_odometry_integrator.sv
// Top level of the differential-drive odometry integrator with its sequencer.
`timescale 1ns / 1ps
// Each item either integrates one wheel-speed sample into the pose or clears the pose,
// and returns one result item with the pose, the yaw quaternion, the speed and the yaw
// rate. Work is done one item at a time through three shared serial units: a
// shift-and-add multiplier, a restoring divider by one million and an iterative
// CORDIC. An integrate item runs nine products, two divisions and two CORDIC passes.
// A reset item needs only the quaternion pass. A new item is accepted while a
// finished result still waits in the output register; the sequencer only holds in its
// last state if that register is still full and out_stall is high. Configuration
// writes are always ready and must only be issued while the block is idle.
module diff_drive_odometry_integrator #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic operation,
  input  logic signed [15:0] right_rpm,
  input  logic signed [15:0] left_rpm,
  input  logic [19:0] elapsed_us,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [47:0] x_position,
  output logic signed [47:0] y_position,
  output logic [31:0] heading_angle,
  output logic signed [31:0] orientation_z,
  output logic signed [31:0] orientation_w,
  output logic signed [31:0] linear_speed,
  output logic signed [31:0] angular_rate,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [23:0] cfg_data
);
  import odo_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -42'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v > 49'sh0_7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -49'sh0_8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  odo_state_t state, state_next;
  logic launched;
  logic accept, out_load;

  // Configuration registers.
  logic [23:0] gain, iwb;

  // Item and working registers.
  logic signed [15:0] r_rpm, l_rpm;
  logic [19:0] dt;
  logic signed [31:0] v16, w16;
  logic signed [33:0] d16;
  logic [51:0] m;
  logic wneg, mneg, div_neg;
  logic [31:0] mid;
  logic signed [31:0] qs, qc, qz, qw;
  logic signed [32:0] vt;
  logic signed [47:0] pose_x, pose_y;
  logic [31:0] pose_heading;

  // Unit interfaces.
  logic mul_start, mul_done, mul_neg;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_AW+MUL_BW-1:0] prod;
  logic cor_start, cor_done;
  logic [31:0] cor_angle;
  odo_trig_t trig;
  logic div_start, div_done;
  logic [DIV_NW-1:0] quo;

  // Derived operands and results.
  logic signed [16:0] sum_rl, dif_rl;
  logic [16:0] sum_mag, dif_mag;
  logic [31:0] v_mag, w_mag, qc_mag, qs_mag;
  logic [33:0] d_mag;
  logic [32:0] vt_mag;
  logic signed [84:0] prod_s;
  logic signed [41:0] sp_v, sp_d;
  logic signed [57:0] sp_w;
  logic signed [62:0] sp_t;
  logic [32:0] r33, delta;
  logic signed [34:0] qv;
  logic signed [48:0] x_sum, y_sum;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  assign sum_rl  = 17'(r_rpm) + 17'(l_rpm);
  assign dif_rl  = 17'(r_rpm) - 17'(l_rpm);
  assign sum_mag = sum_rl[16] ? 17'(-sum_rl) : sum_rl;
  assign dif_mag = dif_rl[16] ? 17'(-dif_rl) : dif_rl;
  assign d_mag   = d16[33] ? 34'(-d16) : d16;
  assign v_mag   = v16[31] ? 32'(-v16) : v16;
  assign w_mag   = w16[31] ? 32'(-w16) : w16;
  assign qc_mag  = qc[31] ? 32'(-qc) : qc;
  assign qs_mag  = qs[31] ? 32'(-qs) : qs;
  assign vt_mag  = vt[32] ? 33'(-vt) : vt;

  // Products are unsigned magnitudes; the sign is put back here exactly.
  assign prod_s = mneg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign sp_v   = prod_s[41:0] + 42'sd256;
  assign sp_d   = prod_s[41:0] + 42'sd128;
  assign sp_w   = prod_s[57:0] + 58'sd32768;
  assign sp_t   = prod_s[62:0] + 63'sd536870912;

  // Heading step is the product shifted down by 38, truncated toward zero.
  assign r33   = prod[70:38];
  assign delta = wneg ? 33'(-r33) : r33;

  // The quotient stays below 2^34 since the dividend is below 2^53.
  assign qv    = div_neg ? -$signed({1'b0, quo[33:0]}) : $signed({1'b0, quo[33:0]});
  assign x_sum = {pose_x[47], pose_x} + 49'(qv);
  assign y_sum = {pose_y[47], pose_y} + 49'(qv);

  odo_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  odo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .trig  (trig)
  );

  odo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DIV_NW-1:0]),
    .done     (div_done),
    .quotient (quo)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (operation == OP_RESET) ? S_COR_Q : S_SUM;
        end
      end
      S_SUM:     if (mul_done) state_next = S_DIF;
      S_DIF:     if (mul_done) state_next = S_W;
      S_W:       if (mul_done) state_next = S_WDT;
      S_WDT:     if (mul_done) state_next = S_HS;
      S_HS:      if (mul_done) state_next = S_COR_MID;
      S_COR_MID: if (cor_done) state_next = S_VC;
      S_VC:      if (mul_done) state_next = S_VCDT;
      S_VCDT:    if (mul_done) state_next = S_DIVX;
      S_DIVX:    if (div_done) state_next = S_VS;
      S_VS:      if (mul_done) state_next = S_VSDT;
      S_VSDT:    if (mul_done) state_next = S_DIVY;
      S_DIVY:    if (div_done) state_next = S_COR_Q;
      S_COR_Q:   if (cor_done) state_next = S_DONE;
      S_DONE:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: unit launches and multiplier operand selection.
  always_comb begin
    mul_start = 1'b0;
    cor_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_neg   = 1'b0;
    cor_angle = {1'b0, pose_heading[31:1]};
    unique case (state)
      S_SUM: begin
        mul_start = !launched;
        mul_a     = MUL_AW'(sum_mag);
        mul_b     = MUL_BW'(gain);
        mul_neg   = sum_rl[16];
      end
      S_DIF: begin
        mul_start = !launched;
        mul_a     = MUL_AW'(dif_mag);
        mul_b     = MUL_BW'(gain);
        mul_neg   = dif_rl[16];
      end
      S_W: begin
        mul_start = !launched;
        mul_a     = MUL_AW'(d_mag);
        mul_b     = MUL_BW'(iwb);
        mul_neg   = d16[33];
      end
      S_WDT: begin
        mul_start = !launched;
        mul_a     = MUL_AW'(w_mag);
        mul_b     = MUL_BW'(dt);
        mul_neg   = w16[31];
      end
      S_HS: begin
        mul_start = !launched;
        mul_a     = m;
        mul_b     = HEADING_SCALE;
      end
      S_COR_MID: begin
        cor_start = !launched;
        cor_angle = mid;
      end
      S_VC: begin
        mul_start = !launched;
        mul_a     = MUL_AW'(v_mag);
        mul_b     = qc_mag;
        mul_neg   = v16[31] ^ qc[31];
      end
      S_VS: begin
        mul_start = !launched;
        mul_a     = MUL_AW'(v_mag);
        mul_b     = qs_mag;
        mul_neg   = v16[31] ^ qs[31];
      end
      S_VCDT, S_VSDT: begin
        mul_start = !launched;
        mul_a     = MUL_AW'(vt_mag);
        mul_b     = MUL_BW'(dt);
        mul_neg   = vt[32];
      end
      S_DIVX, S_DIVY: begin
        div_start = !launched;
      end
      S_COR_Q: begin
        cor_start = !launched;
      end
      S_IDLE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        launched <= 1'b0;
      end else if (mul_start || cor_start || div_start) begin
        launched <= 1'b1;
      end
    end
  end

  // Configuration registers and pose state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain         <= GAIN_RESET;
      iwb          <= IWB_RESET;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GAIN) begin
          gain <= cfg_data;
        end else begin
          iwb <= cfg_data;
        end
      end
      if (accept && operation == OP_RESET) begin
        pose_x       <= '0;
        pose_y       <= '0;
        pose_heading <= '0;
      end
      if (state == S_HS && mul_done) begin
        pose_heading <= pose_heading + delta[31:0];
      end
      if (state == S_DIVX && div_done) begin
        pose_x <= sat48(x_sum);
      end
      if (state == S_DIVY && div_done) begin
        pose_y <= sat48(y_sum);
      end
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_rpm <= right_rpm;
      l_rpm <= left_rpm;
      dt    <= elapsed_us;
      if (operation == OP_RESET) begin
        v16 <= '0;
        w16 <= '0;
      end
    end
    if (mul_start) begin
      mneg <= mul_neg;
    end
    if (mul_done) begin
      unique case (state)
        S_SUM: v16 <= sat32(sp_v >>> 9);
        S_DIF: d16 <= sp_d[41:8];
        S_W:   w16 <= sat32(sp_w[57:16]);
        S_WDT: begin
          m    <= prod[51:0];
          wneg <= mneg;
        end
        S_HS:  mid <= pose_heading + delta[32:1];
        S_VC, S_VS: vt <= sp_t[62:30];
        S_VCDT, S_VSDT: div_neg <= mneg;
        default: begin
        end
      endcase
    end
    if (cor_done) begin
      if (state == S_COR_MID) begin
        qs <= trig.sin_v;
        qc <= trig.cos_v;
      end else begin
        qz <= trig.sin_v;
        qw <= trig.cos_v;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      x_position    <= pose_x;
      y_position    <= pose_y;
      heading_angle <= pose_heading;
      orientation_z <= qz;
      orientation_w <= qw;
      linear_speed  <= v16;
      angular_rate  <= w16;
    end
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && cor_start) && !(mul_start && div_start))
    else $error("two serial units launched together");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_RESET) |=> (pose_x == '0 && pose_y == '0 &&
                                           pose_heading == '0))
    else $error("reset item did not clear the pose");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result presented outside the final state");

  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (orientation_z <= 32'sd1073741824 && orientation_z >= -32'sd1073741824 &&
                   orientation_w <= 32'sd1073741824 && orientation_w >= -32'sd1073741824))
    else $error("quaternion component out of range");

endmodule
